// ===== src/lem_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency envelope monitor package
// Shared widths, command codes, constants and divider handshake types.
// ----------------------------------------------------------------------------
package lem_pkg;

	localparam int TIME_W      = 32;
	localparam int CMD_W       = 3;
	localparam int CAT_W       = 2;
	localparam int NUM_CAT     = 4;
	localparam int DIVIDEND_W  = 64;
	localparam int PRODUCT_W   = 52;
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 160;
	localparam int OUT_TUSER_W = 3;
	localparam int CFG_IDX_W   = 1;

	// Command codes carried on the input tuser.
	localparam logic [CMD_W-1:0] CMD_ENTER    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TRACKS   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_PULSE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_EMIT     = 3'd5;
	localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd7;

	// Sample categories.
	localparam logic [CAT_W-1:0] CAT_GAP      = 2'd0;
	localparam logic [CAT_W-1:0] CAT_SERVICE  = 2'd1;
	localparam logic [CAT_W-1:0] CAT_DISPATCH = 2'd2;
	localparam logic [CAT_W-1:0] CAT_TRACKS   = 2'd3;
	localparam logic [CAT_W-1:0] CAT_LAST     = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SOFT_CEILING  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_INTERVAL = 1'd1;

	localparam logic [TIME_W-1:0] SOFT_CEILING_RESET  = 32'd1000;
	localparam logic [TIME_W-1:0] EMIT_INTERVAL_RESET = 32'd1000000;
	localparam logic [TIME_W-1:0] MICROS_PER_SECOND   = 32'd1000000;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [TIME_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== src/latency_envelope_monitor_core.sv =====
// ----------------------------------------------------------------------------
// Latency envelope monitor core
// Windowed maximum and over-ceiling tracking of gap, service, dispatch and update
// latencies, with a pulse rate reported on each window emission.
// ----------------------------------------------------------------------------
// The block takes one command at a time and drops s_tready while it works.
// Enter, exit, dispatch and tracks commands go through a sample state when
// they produce a sample; pulse, clear and emits that do not close the
// window return to idle after the execute state. A peek goes straight to
// the output and streams four rows, one per category, at one row per cycle
// while m_tready is high. An emit that closes the window computes the pulse
// rate: the pulse count is multiplied by one million in a registered step
// and then divided by the elapsed window time in a serial divider that
// retires two quotient bits per cycle, after which the four rows are sent.
// The divider is skipped when the elapsed time is zero, and the rate is then
// reported as zero. The window is cleared once the last emitted row has been
// transferred, so the rows always show the window that was closed.
// ----------------------------------------------------------------------------
module latency_envelope_monitor_core import lem_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream. tdata: time_us[31:0]. tuser: command[2:0].
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [IN_TUSER_W-1:0]  s_tuser,
	// Output stream. tdata: max_us[31:0], over_count[63:32],
	// clock_pulses[95:64], window_elapsed_us[127:96],
	// pulses_per_second[159:128]. tuser: emitted[0], category[2:1].
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [OUT_TUSER_W-1:0] m_tuser,
	output logic                   m_tlast,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [TIME_W-1:0]      cfg_wdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SAMPLE = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_DSTART = 3'd4;
	localparam logic [2:0] ST_DIV    = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]           state_q;

	// Configuration registers.
	logic [TIME_W-1:0]    soft_ceiling_q;
	logic [TIME_W-1:0]    emit_interval_q;

	// Window state.
	logic [TIME_W-1:0]    cat_max_q  [NUM_CAT];
	logic [TIME_W-1:0]    cat_over_q [NUM_CAT];
	logic [TIME_W-1:0]    pulse_q;
	logic [TIME_W-1:0]    last_exit_q;
	logic [TIME_W-1:0]    enter_time_q;
	logic                 in_service_q;
	logic [TIME_W-1:0]    win_start_q;
	logic [TIME_W-1:0]    last_emit_q;

	// Per-command working registers.
	logic [CMD_W-1:0]     cmd_q;
	logic [TIME_W-1:0]    t_q;
	logic [TIME_W-1:0]    sample_q;
	logic [CAT_W-1:0]     cat_q;      // sample category, then the row index
	logic                 emitted_q;
	logic [TIME_W-1:0]    elapsed_q;
	logic [TIME_W-1:0]    rate_q;
	logic [PRODUCT_W-1:0] product_q;

	logic [TIME_W-1:0]    since_emit;
	logic [TIME_W-1:0]    since_start;
	logic                 interval_short;

	div_req_t             div_req;
	div_rsp_t             div_rsp;

	lem_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign div_req.start    = (state_q == ST_DSTART);
	assign div_req.dividend = DIVIDEND_W'(product_q);
	assign div_req.divisor  = elapsed_q;

	assign since_emit     = t_q - last_emit_q;
	assign since_start    = t_q - win_start_q;
	assign interval_short = (last_emit_q != '0) && (since_emit < emit_interval_q);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {rate_q, elapsed_q, pulse_q, cat_over_q[cat_q], cat_max_q[cat_q]};
	assign m_tuser  = {cat_q, emitted_q};
	assign m_tlast  = (cat_q == CAT_LAST);

	// Configuration is only to be written while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_ceiling_q  <= SOFT_CEILING_RESET;
			emit_interval_q <= EMIT_INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOFT_CEILING:  soft_ceiling_q  <= cfg_wdata;
				REG_EMIT_INTERVAL: emit_interval_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pulse_q      <= '0;
			last_exit_q  <= '0;
			enter_time_q <= '0;
			in_service_q <= 1'b0;
			win_start_q  <= '0;
			last_emit_q  <= '0;
			cat_q        <= '0;
			emitted_q    <= 1'b0;
			for (int i = 0; i < NUM_CAT; i++) begin
				cat_max_q[i]  <= '0;
				cat_over_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					case (cmd_q)
						CMD_ENTER: begin
							if (win_start_q == '0) begin
								win_start_q <= t_q;
							end
							// A gap sample needs an earlier exit.
							if (last_exit_q != '0) begin
								cat_q   <= CAT_GAP;
								state_q <= ST_SAMPLE;
							end
							enter_time_q <= t_q;
							in_service_q <= 1'b1;
						end
						CMD_EXIT: begin
							if (in_service_q) begin
								cat_q        <= CAT_SERVICE;
								in_service_q <= 1'b0;
								state_q      <= ST_SAMPLE;
							end
							last_exit_q <= t_q;
						end
						CMD_DISPATCH: begin
							cat_q   <= CAT_DISPATCH;
							state_q <= ST_SAMPLE;
						end
						CMD_TRACKS: begin
							cat_q   <= CAT_TRACKS;
							state_q <= ST_SAMPLE;
						end
						CMD_PULSE: begin
							pulse_q <= pulse_q + 1'b1;
						end
						CMD_EMIT: begin
							if (win_start_q == '0) begin
								// An emit with no open window only opens it.
								win_start_q <= t_q;
								last_emit_q <= t_q;
							end else if (!interval_short) begin
								emitted_q <= 1'b1;
								cat_q     <= '0;
								if (since_start == '0) begin
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_MUL;
								end
							end
						end
						CMD_PEEK: begin
							emitted_q <= 1'b0;
							cat_q     <= '0;
							state_q   <= ST_OUT;
						end
						CMD_CLEAR: begin
							pulse_q      <= '0;
							last_exit_q  <= '0;
							enter_time_q <= '0;
							in_service_q <= 1'b0;
							win_start_q  <= '0;
							last_emit_q  <= '0;
							for (int i = 0; i < NUM_CAT; i++) begin
								cat_max_q[i]  <= '0;
								cat_over_q[i] <= '0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SAMPLE: begin
					if (sample_q > cat_max_q[cat_q]) begin
						cat_max_q[cat_q] <= sample_q;
					end
					if (sample_q > soft_ceiling_q) begin
						cat_over_q[cat_q] <= cat_over_q[cat_q] + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_DSTART;
				end
				ST_DSTART: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_tready) begin
						cat_q <= cat_q + 1'b1;
						if (cat_q == CAT_LAST) begin
							state_q <= ST_IDLE;
							// Close the window after the last emitted row.
							if (emitted_q) begin
								pulse_q     <= '0;
								win_start_q <= t_q;
								last_emit_q <= t_q;
								for (int i = 0; i < NUM_CAT; i++) begin
									cat_max_q[i]  <= '0;
									cat_over_q[i] <= '0;
								end
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			cmd_q <= s_tuser;
			t_q   <= s_tdata;
		end
		if (state_q == ST_EXEC) begin
			case (cmd_q)
				CMD_ENTER:    sample_q <= t_q - last_exit_q;
				CMD_EXIT:     sample_q <= t_q - enter_time_q;
				default:      sample_q <= t_q;
			endcase
			if (cmd_q == CMD_PEEK) begin
				elapsed_q <= (win_start_q != '0 && t_q != '0) ? since_start : '0;
			end else begin
				elapsed_q <= since_start;
			end
			rate_q <= '0;
		end
		if (state_q == ST_MUL) begin
			product_q <= PRODUCT_W'(pulse_q) * PRODUCT_W'(MICROS_PER_SECOND);
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			rate_q <= div_rsp.quotient;
		end
	end

endmodule

// ===== src/lem_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 64 by 32 bit division, two quotient bits per cycle, keeping the
// low 32 bits of the quotient.
// ----------------------------------------------------------------------------
module lem_div import lem_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = 5;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [TIME_W-1:0]     dvs_q;
	logic [TIME_W-1:0]     rem_q;
	logic [TIME_W-1:0]     quot_q;

	logic [TIME_W:0]       step1;
	logic [TIME_W:0]       step2;

	// One restoring step: result is {quotient bit, new remainder}.
	function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] rem,
			input logic nbit, input logic [TIME_W-1:0] dvs);
		logic [TIME_W+1:0] diff;
		logic [TIME_W:0]   shifted;
		shifted = {rem, nbit};
		diff    = {1'b0, shifted} - {2'b00, dvs};
		if (diff[TIME_W+1]) begin
			div_step = {1'b0, shifted[TIME_W-1:0]};
		end else begin
			div_step = {1'b1, diff[TIME_W-1:0]};
		end
	endfunction

	assign step1 = div_step(rem_q, dvd_q[DIVIDEND_W-1], dvs_q);
	assign step2 = div_step(step1[TIME_W-1:0], dvd_q[DIVIDEND_W-2], dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == {CNT_W{1'b1}}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dvs_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DIVIDEND_W-3:0], 2'b00};
			rem_q  <= step2[TIME_W-1:0];
			quot_q <= {quot_q[TIME_W-3:0], step1[TIME_W], step2[TIME_W]};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

// ===== src/lem_assert.sv =====
// ----------------------------------------------------------------------------
// Latency envelope monitor checker
// Port-level checks of the report stream, bound to the core.
// ----------------------------------------------------------------------------
module lem_assert import lem_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser,
	input logic                   m_tlast
);

	// A stalled row holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output row changed while stalled");

	// No new command is taken while a report is streaming.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready during report");

	// Rows of a run follow in category order without a gap.
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
			m_tvalid && (m_tuser[2:1] == $past(m_tuser[2:1]) + 2'd1))
		else $error("report row out of order");

	// The last flag sits on the final category only.
	a_last_cat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser[2:1] == CAT_LAST)))
		else $error("tlast not on final category");

	// Peek rows carry no rate.
	a_peek_rate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[159:128] == '0))
		else $error("peek row with nonzero rate");

endmodule

bind latency_envelope_monitor_core lem_assert u_lem_assert (.*);
